// ----- rtl/core/hex_mesh_connectivity_gen_top_macros.svh -----
// Assertion macros for the hex mesh connectivity generator.
// Included by the top level; no other dependencies.
`ifndef HEX_MESH_CONNECTIVITY_GEN_TOP_MACROS_SVH
`define HEX_MESH_CONNECTIVITY_GEN_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define HMCG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmcg assertion failed");
// antecedent implies consequent in the next cycle
`define HMCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmcg assertion failed");
`else
`define HMCG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HMCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/hmcg_pkg.sv -----
// Package for the hex mesh connectivity generator: payload and control
// structs, register indexes and helper functions. No dependencies.
package hmcg_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_ELEMS_X    = 8'd0;
    localparam logic [7:0] REG_ELEMS_Y    = 8'd1;
    localparam logic [7:0] REG_ELEMS_Z    = 8'd2;
    localparam logic [7:0] REG_POLY_ORDER = 8'd3;

    // one input item
    typedef struct packed {
        logic [7:0] elem_x;
        logic [7:0] elem_y;
        logic [7:0] elem_z;
    } hmcg_in_t;

    // one result item
    typedef struct packed {
        logic [23:0] element_index;
        logic [5:0]  local_node;
        logic [28:0] global_node;
        logic        last;
        logic        bad_element;
    } hmcg_out_t;

    // effective configuration and derived grid strides
    typedef struct packed {
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [7:0]  cz;
        logic [1:0]  p;
        logic [9:0]  nx;
        logic [9:0]  ny;
        logic [19:0] nxny;
    } hmcg_cfg_t;

    // element descriptor handed from the element pipe to the node sequencer
    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [23:0] elem_idx;
        logic [28:0] base;
    } hmcg_elem_t;

    // local number of the final node of an element of order p
    function automatic logic [5:0] last_local(input logic [1:0] p);
        logic [5:0] r;
        case (p)
            2'd2:    r = 6'd26;
            2'd3:    r = 6'd63;
            default: r = 6'd7;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/hmcg_elem_pipe.sv -----
// Element pipe: range check, element index and base node per element.
// Three stallable stages; depends on hmcg_pkg.
module hmcg_elem_pipe
    import hmcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hmcg_cfg_t  cfg,
    input  logic       start,
    output logic       busy,
    input  hmcg_in_t   elem,
    input  logic       take,
    output hmcg_elem_t desc
);

    // stage registers
    logic        s1_v_reg, s1_v_next;
    logic [7:0]  s1_ex_reg, s1_ey_reg, s1_ez_reg;

    logic        s2_v_reg, s2_v_next;
    logic        s2_bad_reg;
    logic [7:0]  s2_ex_reg, s2_ey_reg;
    logic [15:0] s2_t_reg;
    logic [9:0]  s2_px_reg, s2_py_reg, s2_pz_reg;

    logic        s3_v_reg, s3_v_next;
    logic        s3_bad_reg;
    logic [7:0]  s3_ex_reg;
    logic [16:0] s3_u_reg;
    logic [9:0]  s3_px_reg;
    logic [20:0] s3_v_val_reg;

    logic        acc, s1_mv, s2_mv, s3_mv;
    logic        bad_c;
    logic [15:0] t_c;
    logic [9:0]  px_c, py_c, pz_c;
    logic [16:0] u_c;
    logic [20:0] v_c;
    logic [24:0] eidx_c;
    logic [30:0] base_c;

    // flow control: a stage moves when the next one is empty or moving
    always_comb
    begin
        s3_mv = s3_v_reg & take;
        s2_mv = s2_v_reg & (~s3_v_reg | s3_mv);
        s1_mv = s1_v_reg & (~s2_v_reg | s2_mv);
        busy  = s1_v_reg & ~s1_mv;
        acc   = start & ~busy;
    end

    // stage 1 -> 2: range check and first products
    always_comb
    begin
        bad_c = (s1_ex_reg >= cfg.cx) | (s1_ey_reg >= cfg.cy) | (s1_ez_reg >= cfg.cz);
        t_c   = 16'(cfg.cy) * 16'(s1_ez_reg);
        px_c  = 10'(cfg.p) * 10'(s1_ex_reg);
        py_c  = 10'(cfg.p) * 10'(s1_ey_reg);
        pz_c  = 10'(cfg.p) * 10'(s1_ez_reg);
    end

    // stage 2 -> 3: row term of element index, plane term of base
    always_comb
    begin
        u_c = 17'(s2_ey_reg) + 17'(s2_t_reg);
        v_c = 21'(s2_py_reg) + 21'(cfg.ny) * 21'(s2_pz_reg);
    end

    // stage 3 -> sequencer: final products
    always_comb
    begin
        eidx_c        = 25'(s3_ex_reg) + 25'(cfg.cx) * 25'(s3_u_reg);
        base_c        = 31'(s3_px_reg) + 31'(cfg.nx) * 31'(s3_v_val_reg);
        desc.valid    = s3_v_reg;
        desc.bad      = s3_bad_reg;
        desc.elem_idx = eidx_c[23:0];
        desc.base     = base_c[28:0];
    end

    // valid bits
    always_comb
    begin
        s1_v_next = acc ? 1'b1 : (s1_mv ? 1'b0 : s1_v_reg);
        s2_v_next = s1_mv ? 1'b1 : (s2_mv ? 1'b0 : s2_v_reg);
        s3_v_next = s2_mv ? 1'b1 : (s3_mv ? 1'b0 : s3_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ex_reg <= elem.elem_x;
            s1_ey_reg <= elem.elem_y;
            s1_ez_reg <= elem.elem_z;
        end
        if (s1_mv)
        begin
            s2_bad_reg <= bad_c;
            s2_ex_reg  <= s1_ex_reg;
            s2_ey_reg  <= s1_ey_reg;
            s2_t_reg   <= t_c;
            s2_px_reg  <= px_c;
            s2_py_reg  <= py_c;
            s2_pz_reg  <= pz_c;
        end
        if (s2_mv)
        begin
            s3_bad_reg   <= s2_bad_reg;
            s3_ex_reg    <= s2_ex_reg;
            s3_u_reg     <= u_c;
            s3_px_reg    <= s2_px_reg;
            s3_v_val_reg <= v_c;
        end
    end

endmodule

// ----- rtl/core/hmcg_node_seq.sv -----
// Node sequencer: walks the (p+1)^3 local nodes of one element, one per
// cycle, with running row and plane bases; registered result. Uses hmcg_pkg.
module hmcg_node_seq
    import hmcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hmcg_cfg_t  cfg,
    input  hmcg_elem_t desc,
    output logic       take,
    output logic       strobe,
    output hmcg_out_t  result
);

    logic        act_reg, act_next;
    logic        bad_reg, bad_next;
    logic [23:0] eidx_reg, eidx_next;
    logic [1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [5:0]  loc_reg, loc_next;
    logic [28:0] row_reg, row_next, plane_reg, plane_next;

    logic        strobe_reg, strobe_next;
    hmcg_out_t   result_reg, result_next;

    logic        is_last;
    logic [28:0] plane_inc;

    // end of element and hand-off of the next descriptor
    always_comb
    begin
        is_last = bad_reg | ((i_reg == cfg.p) & (j_reg == cfg.p) & (k_reg == cfg.p));
        take    = ~act_reg | is_last;
    end

    // counters and running bases
    always_comb
    begin
        act_next   = act_reg;
        bad_next   = bad_reg;
        eidx_next  = eidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        loc_next   = loc_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        plane_inc  = plane_reg + {9'd0, cfg.nxny};
        if (take & desc.valid)
        begin
            act_next   = 1'b1;
            bad_next   = desc.bad;
            eidx_next  = desc.elem_idx;
            i_next     = 2'd0;
            j_next     = 2'd0;
            k_next     = 2'd0;
            loc_next   = 6'd0;
            row_next   = desc.base;
            plane_next = desc.base;
        end
        else if (act_reg & is_last)
        begin
            act_next = 1'b0;
        end
        else if (act_reg)
        begin
            loc_next = loc_reg + 6'd1;
            if (i_reg != cfg.p)
            begin
                i_next = i_reg + 2'd1;
            end
            else
            begin
                i_next = 2'd0;
                if (j_reg != cfg.p)
                begin
                    j_next   = j_reg + 2'd1;
                    row_next = row_reg + {19'd0, cfg.nx};
                end
                else
                begin
                    j_next     = 2'd0;
                    k_next     = k_reg + 2'd1;
                    plane_next = plane_inc;
                    row_next   = plane_inc;
                end
            end
        end
    end

    // result of the current node
    always_comb
    begin
        strobe_next = act_reg;
        if (bad_reg)
        begin
            result_next.element_index = 24'd0;
            result_next.local_node    = 6'd0;
            result_next.global_node   = 29'd0;
            result_next.last          = 1'b1;
            result_next.bad_element   = 1'b1;
        end
        else
        begin
            result_next.element_index = eidx_reg;
            result_next.local_node    = loc_reg;
            result_next.global_node   = row_reg + {27'd0, i_reg};
            result_next.last          = is_last;
            result_next.bad_element   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            act_reg    <= act_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg    <= bad_next;
        eidx_reg   <= eidx_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        loc_reg    <= loc_next;
        row_reg    <= row_next;
        plane_reg  <= plane_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/hex_mesh_connectivity_gen_top.sv -----
// Hex mesh connectivity generator, top level.
// Results pass the element pipe stages and the sequencer's result register; one result
// per cycle within an element, (p+1)^3 results per element (one for a rejected one).
// Elements enter back to back through a three-stage element pipe; busy only
// while the pipe is full. The receiver cannot stall results.
// Reset (rst_n, async low): pipe and sequencer empty, all configuration registers read 1.
`include "hex_mesh_connectivity_gen_top_macros.svh"
module hex_mesh_connectivity_gen_top
    import hmcg_pkg::*;
#(
    parameter int MAX_ELEMS_PER_AXIS = 255,
    parameter int MAX_ORDER          = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       start,
    output logic       busy,
    input  hmcg_in_t   elem,
    output logic       strobe,
    output hmcg_out_t  result
);

    logic [7:0] elems_x_reg, elems_y_reg, elems_z_reg;
    logic [1:0] poly_order_reg;
    hmcg_cfg_t  cfg_reg, cfg_next;
    hmcg_elem_t desc;
    logic       take;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elems_x_reg    <= 8'd1;
            elems_y_reg    <= 8'd1;
            elems_z_reg    <= 8'd1;
            poly_order_reg <= 2'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ELEMS_X:    elems_x_reg    <= cfg_data;
                REG_ELEMS_Y:    elems_y_reg    <= cfg_data;
                REG_ELEMS_Z:    elems_z_reg    <= cfg_data;
                REG_POLY_ORDER: poly_order_reg <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    // effective counts and order, clamped
    function automatic logic [7:0] eff_count(input logic [7:0] v);
        logic [7:0] r;
        if (v == 8'd0)
            r = 8'd1;
        else if (int'(v) > MAX_ELEMS_PER_AXIS)
            r = 8'(MAX_ELEMS_PER_AXIS);
        else
            r = v;
        return r;
    endfunction

    // derived strides, registered; nxny is taken from the registered nx/ny, so it follows them in the next cycle
    always_comb
    begin
        cfg_next.cx = eff_count(elems_x_reg);
        cfg_next.cy = eff_count(elems_y_reg);
        cfg_next.cz = eff_count(elems_z_reg);
        if (poly_order_reg == 2'd0)
            cfg_next.p = 2'd1;
        else if (int'(poly_order_reg) > MAX_ORDER)
            cfg_next.p = 2'(MAX_ORDER);
        else
            cfg_next.p = poly_order_reg;
        cfg_next.nx   = 10'(cfg_reg.p) * 10'(cfg_reg.cx) + 10'd1;
        cfg_next.ny   = 10'(cfg_reg.p) * 10'(cfg_reg.cy) + 10'd1;
        cfg_next.nxny = 20'(cfg_reg.nx) * 20'(cfg_reg.ny);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cx   <= 8'd1;
            cfg_reg.cy   <= 8'd1;
            cfg_reg.cz   <= 8'd1;
            cfg_reg.p    <= 2'd1;
            cfg_reg.nx   <= 10'd2;
            cfg_reg.ny   <= 10'd2;
            cfg_reg.nxny <= 20'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hmcg_elem_pipe u_elem_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .start (start),
        .busy  (busy),
        .elem  (elem),
        .take  (take),
        .desc  (desc)
    );

    hmcg_node_seq u_node_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .desc   (desc),
        .take   (take),
        .strobe (strobe),
        .result (result)
    );

    // a rejected element gives one zeroed, final result
    `HMCG_ASSERT_SAME(a_bad_zero, clk, rst_n, strobe && result.bad_element, result.last && result.global_node == 29'd0 && result.local_node == 6'd0)
    // the final node of a good element has the highest local number
    `HMCG_ASSERT_SAME(a_last_local, clk, rst_n, strobe && result.last && !result.bad_element, result.local_node == last_local(cfg_reg.p))
    // nodes of one element come in consecutive cycles
    `HMCG_ASSERT_NEXT(a_no_gap, clk, rst_n, strobe && !result.last, strobe)
    // local numbers count up by one within an element
    `HMCG_ASSERT_NEXT(a_local_step, clk, rst_n, strobe && !result.last, result.local_node == $past(result.local_node) + 6'd1)

endmodule

// ----- test/tb_hex_mesh_connectivity_gen_top.sv -----
// Self-checking bench for hex_mesh_connectivity_gen_top: element transfers in,
// node connectivity results checked against an in-bench predictor.
// Depends on hmcg_pkg and the hex_mesh_connectivity_gen_top RTL.
module tb_hex_mesh_connectivity_gen_top
    import hmcg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_AXIS_COUNT    = 255;
    localparam int          MAX_POLY_ORDER    = 3;
    localparam int          SETTLE_CYCLES     = 8;
    localparam int          CYCLE_LIMIT       = 300000;
    localparam logic [7:0]  REG_UNMAPPED      = 8'd4;
    localparam logic [7:0]  REG_LAST_UNMAPPED = 8'd255;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;
    logic       start     = 1'b0;
    logic       busy;
    hmcg_in_t   elem      = '0;
    logic       strobe;
    hmcg_out_t  result;

    // shadow copy of the mesh registers
    logic [7:0] reg_elems_x = 8'd1;
    logic [7:0] reg_elems_y = 8'd1;
    logic [7:0] reg_elems_z = 8'd1;
    logic [1:0] reg_poly    = 2'd1;

    hmcg_out_t  pending_nodes[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         burst_left     = 0;
    bit         sender_steady  = 1'b0;

    hex_mesh_connectivity_gen_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .elem      (elem),
        .strobe    (strobe),
        .result    (result)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_nodes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // effective axis count: zero reads as one, clamp at the parameter
    function automatic int unsigned axis_count(input logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (v > MAX_AXIS_COUNT)
            return MAX_AXIS_COUNT;
        return {24'd0, v};
    endfunction

    // effective order: zero reads as one, clamp at the parameter
    function automatic int unsigned order_of(input logic [1:0] v);
        if (v == 2'd0)
            return 1;
        if (v > MAX_POLY_ORDER)
            return MAX_POLY_ORDER;
        return {30'd0, v};
    endfunction

    // mostly in range, sometimes past the configured count
    function automatic logic [7:0] pick_coord(input int unsigned cnt);
        if ($urandom_range(0, 11) != 0)
            return 8'($urandom_range(0, cnt - 1));
        return 8'($urandom_range(cnt, 255));
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // node list of one element under the current mesh registers
    task automatic predict_element_nodes(input hmcg_in_t e);
        int unsigned     cx, cy, cz, p, n, nx, ny, ex, ey, ez, li, lj, lk;
        longint unsigned base, node, idx, ln;
        hmcg_out_t       r;
        cx = axis_count(reg_elems_x);
        cy = axis_count(reg_elems_y);
        cz = axis_count(reg_elems_z);
        p  = order_of(reg_poly);
        ex = {24'd0, e.elem_x};
        ey = {24'd0, e.elem_y};
        ez = {24'd0, e.elem_z};
        if (ex >= cx || ey >= cy || ez >= cz)
        begin
            // rejected element: one flagged result
            r = '0;
            r.last = 1'b1;
            r.bad_element = 1'b1;
            pending_nodes.push_back(r);
        end
        else
        begin
            n    = p + 1;
            nx   = p * cx + 1;
            ny   = p * cy + 1;
            idx  = 64'(ex) + 64'(cx) * (64'(ey) + 64'(cy) * 64'(ez));
            base = 64'(p) * 64'(ex)
                   + 64'(nx) * (64'(p) * 64'(ey) + 64'(ny) * 64'(p) * 64'(ez));
            for (lk = 0; lk < n; lk++)
            begin
                for (lj = 0; lj < n; lj++)
                begin
                    for (li = 0; li < n; li++)
                    begin
                        ln   = 64'(li + n * (lj + n * lk));
                        node = base + 64'(li) + 64'(nx) * (64'(lj) + 64'(ny) * 64'(lk));
                        r.element_index = idx[23:0];
                        r.local_node    = ln[5:0];
                        r.global_node   = node[28:0];
                        r.last          = (li == p && lj == p && lk == p);
                        r.bad_element   = 1'b0;
                        pending_nodes.push_back(r);
                    end
                end
            end
        end
    endtask

    // result checker: one result per strobe, compared with the oldest expectation
    always @(posedge clk)
    begin : check_results
        hmcg_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_nodes.size() == 0)
                report_mismatch("result strobe with nothing pending", 1, 0);
            else
            begin
                want = pending_nodes.pop_front();
                if (result.element_index !== want.element_index)
                    report_mismatch("element_index", 64'(result.element_index),
                                    64'(want.element_index));
                if (result.local_node !== want.local_node)
                    report_mismatch("local_node", 64'(result.local_node),
                                    64'(want.local_node));
                if (result.global_node !== want.global_node)
                    report_mismatch("global_node", 64'(result.global_node),
                                    64'(want.global_node));
                if (result.last !== want.last)
                    report_mismatch("last", 64'(result.last), 64'(want.last));
                if (result.bad_element !== want.bad_element)
                    report_mismatch("bad_element", 64'(result.bad_element),
                                    64'(want.bad_element));
            end
        end
    end

    // one element transfer, with bursts and gaps unless the sender is steady
    task automatic send_elem(input hmcg_in_t e);
        int gap;
        if (!sender_steady && burst_left == 0)
        begin
            gap = int'($urandom_range(1, 12));
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = int'($urandom_range(1, 16));
        end
        start <= 1'b1;
        elem  <= e;
        do
            @(posedge clk);
        while (busy);
        predict_element_nodes(e);
        if (burst_left > 0)
            burst_left--;
    endtask

    // sender pause until every pending result has come, then a settle time
    task automatic wait_idle();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_nodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write transfer; valid stays up for a following write
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ELEMS_X:    reg_elems_x = data;
            REG_ELEMS_Y:    reg_elems_y = data;
            REG_ELEMS_Z:    reg_elems_z = data;
            REG_POLY_ORDER: reg_poly    = data[1:0];
            default:        ;
        endcase
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_mesh(input logic [7:0] x, input logic [7:0] y,
                                  input logic [7:0] z, input logic [7:0] ord);
        wait_idle();
        write_reg(REG_ELEMS_X, x);
        write_reg(REG_ELEMS_Y, y);
        write_reg(REG_ELEMS_Z, z);
        write_reg(REG_POLY_ORDER, ord);
        close_cfg();
    endtask

    task automatic send_xyz(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
        hmcg_in_t e;
        e.elem_x = x;
        e.elem_y = y;
        e.elem_z = z;
        send_elem(e);
    endtask

    // reset values: single order-one element, anything else rejected
    task automatic test_reset_defaults();
        send_xyz(8'd0, 8'd0, 8'd0);
        send_xyz(8'd1, 8'd0, 8'd0);
        send_xyz(8'd0, 8'd0, 8'd1);
        send_xyz(8'd255, 8'd255, 8'd255);
    endtask

    // zero counts and order, unmapped indexes, order bits masked from wide data
    task automatic test_register_corners();
        wait_idle();
        write_reg(REG_ELEMS_X, 8'd0);
        write_reg(REG_ELEMS_Y, 8'd0);
        write_reg(REG_ELEMS_Z, 8'd0);
        write_reg(REG_POLY_ORDER, 8'd0);
        write_reg(REG_UNMAPPED, 8'h07);
        write_reg(REG_LAST_UNMAPPED, 8'hFF);
        close_cfg();
        send_xyz(8'd0, 8'd0, 8'd0);
        send_xyz(8'd1, 8'd0, 8'd0);
        send_xyz(8'd0, 8'd1, 8'd0);
        send_xyz(8'd0, 8'd0, 8'd1);
        configure_mesh(8'd3, 8'd2, 8'd1, 8'hFE);
        send_xyz(8'd2, 8'd1, 8'd0);
        send_xyz(8'd0, 8'd0, 8'd0);
        send_xyz(8'd3, 8'd0, 8'd0);
    endtask

    // largest mesh at highest order: widest node numbers
    task automatic test_largest_mesh();
        configure_mesh(8'd255, 8'd255, 8'd255, 8'd3);
        send_xyz(8'd254, 8'd254, 8'd254);
        send_xyz(8'd0, 8'd0, 8'd0);
        send_xyz(8'd254, 8'd0, 8'd0);
        send_xyz(8'd0, 8'd254, 8'd0);
        send_xyz(8'd0, 8'd0, 8'd254);
        send_xyz(8'd255, 8'd255, 8'd255);
        send_xyz(8'd255, 8'd0, 8'd0);
    endtask

    task automatic run_mesh_phase(input logic [7:0] x, input logic [7:0] y,
                                  input logic [7:0] z, input logic [7:0] ord,
                                  input int count, input bit steady, input bit pause_midway);
        hmcg_in_t e;
        int       k;
        configure_mesh(x, y, z, ord);
        sender_steady = steady;
        for (k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                wait_idle();
            e.elem_x = pick_coord(axis_count(reg_elems_x));
            e.elem_y = pick_coord(axis_count(reg_elems_y));
            e.elem_z = pick_coord(axis_count(reg_elems_z));
            send_elem(e);
        end
        sender_steady = 1'b0;
    endtask

    // random elements over a series of mesh settings
    task automatic test_random_meshes();
        run_mesh_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                       8'($urandom_range(1, 8)), 8'd1, 50, 1'b0, 1'b1);
        run_mesh_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)), 8'd2, 40, 1'b1, 1'b0);
        run_mesh_phase(8'd255, 8'd255, 8'd255, 8'd3, 25, 1'b0, 1'b0);
        run_mesh_phase(8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)),
                       8'($urandom_range(0, 16)), 8'($urandom_range(0, 255)),
                       50, 1'b0, 1'b1);
        run_mesh_phase(8'd1, 8'd255, 8'd1, 8'd1, 15, 1'b1, 1'b0);
        run_mesh_phase(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                       8'($urandom_range(1, 4)), 8'd3, 30, 1'b0, 1'b0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_corners();
        test_largest_mesh();
        test_random_meshes();
        wait_idle();
        if (mismatch_count == 0 && pending_nodes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
